[rtl/tire_pressure_sensor_tracker_top_assert.svh]
// Assertion macros for the tire pressure sensor tracker RTL.
// Needs i_clk and i_rst_n in the including module's scope.
`ifndef TIRE_PRESSURE_SENSOR_TRACKER_TOP_ASSERT_SVH
`define TIRE_PRESSURE_SENSOR_TRACKER_TOP_ASSERT_SVH

// same-cycle implication
`define TPST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TPST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tpst_pkg.sv]
// Shared types and constants for the tire pressure sensor tracker.
// No dependencies.
`timescale 1ns / 1ps

package tpst_pkg;

    localparam int WHEEL_COUNT = 4;
    localparam int WHEEL_SLOTS = 4;
    localparam int WIDX_W      = 2;
    localparam int TIME_BITS   = 48;
    localparam int ADDR_W      = 56;
    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 56;

    // pressure = (raw - 147) / 10, divide via reciprocal multiply, exact for 16-bit values
    localparam logic [RAW_W-1:0] PRESS_OFFSET = 16'd147;
    localparam logic [RAW_W-1:0] RECIP10      = 16'hCCCD;
    localparam int               RECIP_SHIFT  = 19;
    localparam int               PROD_W       = 2 * RAW_W;

    localparam logic [BYTE_W-1:0]    LIMIT_RESET   = 8'd32;
    localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = 48'd10000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHEEL0  = 3'd0,
        CFG_WHEEL1  = 3'd1,
        CFG_WHEEL2  = 3'd2,
        CFG_WHEEL3  = 3'd3,
        CFG_LIMIT   = 3'd4,
        CFG_TIMEOUT = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OP_PACKET = 1'b0,
        OP_CHECK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_CALC   = 2'd1,
        S_COMMIT = 2'd2
    } t_state;

    typedef struct packed {
        logic load;
        logic calc;
        logic commit;
    } t_dp_cmd;

endpackage

[rtl/tpst_datapath.sv]
// Datapath: config registers, per-wheel state, address match, pressure decode, timeout check.
// Depends on tpst_pkg; sequenced by tpst_ctrl through t_dp_cmd.
`timescale 1ns / 1ps

module tpst_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tpst_pkg::t_dp_cmd                i_cmd,
    input  logic                             i_op,
    input  logic [tpst_pkg::ADDR_W-1:0]      i_sensor_address,
    input  logic [tpst_pkg::BYTE_W-1:0]      i_battery_byte,
    input  logic [tpst_pkg::BYTE_W-1:0]      i_temperature_byte,
    input  logic [tpst_pkg::RAW_W-1:0]       i_raw_pressure,
    input  logic [tpst_pkg::TIME_BITS-1:0]   i_now_time,
    input  logic                             i_cfg_we,
    input  logic [tpst_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tpst_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_matched,
    output logic [tpst_pkg::WIDX_W-1:0]      o_wheel_index,
    output logic [tpst_pkg::BYTE_W-1:0]      o_decoded_pressure,
    output logic                             o_warning,
    output logic [tpst_pkg::WHEEL_SLOTS-1:0] o_no_signal_mask
);

    // configuration
    logic [tpst_pkg::ADDR_W-1:0]    r_wheel_addr [tpst_pkg::WHEEL_SLOTS];
    logic [tpst_pkg::BYTE_W-1:0]    r_limit;
    logic [tpst_pkg::TIME_BITS-1:0] r_timeout;

    // captured item
    logic                           r_op;
    logic [tpst_pkg::ADDR_W-1:0]    r_addr;
    logic [tpst_pkg::BYTE_W-1:0]    r_batt;
    logic [tpst_pkg::BYTE_W-1:0]    r_temp;
    logic [tpst_pkg::RAW_W-1:0]     r_raw;
    logic [tpst_pkg::TIME_BITS-1:0] r_now;

    // intermediate results
    logic [tpst_pkg::WHEEL_SLOTS-1:0] r_hit_vec;
    logic [tpst_pkg::WHEEL_SLOTS-1:0] r_over_vec;
    logic [tpst_pkg::PROD_W-1:0]      r_prod;
    logic                             r_neg;

    // wheel state
    logic [tpst_pkg::BYTE_W-1:0]      r_w_press [tpst_pkg::WHEEL_SLOTS];
    logic [tpst_pkg::BYTE_W-1:0]      r_w_temp  [tpst_pkg::WHEEL_SLOTS];
    logic [tpst_pkg::BYTE_W-1:0]      r_w_batt  [tpst_pkg::WHEEL_SLOTS];
    logic [tpst_pkg::TIME_BITS-1:0]   r_w_seen  [tpst_pkg::WHEEL_SLOTS];
    logic [tpst_pkg::WHEEL_SLOTS-1:0] r_no_sig;
    logic                             r_warn;

    // output register
    logic                             r_out_matched;
    logic [tpst_pkg::WIDX_W-1:0]      r_out_idx;
    logic [tpst_pkg::BYTE_W-1:0]      r_out_press;
    logic                             r_out_warn;
    logic [tpst_pkg::WHEEL_SLOTS-1:0] r_out_mask;

    logic [tpst_pkg::RAW_W-1:0]       calc_diff;
    logic                             calc_neg;
    logic [tpst_pkg::WHEEL_SLOTS-1:0] calc_hit;
    logic [tpst_pkg::WHEEL_SLOTS-1:0] calc_over;
    logic [tpst_pkg::TIME_BITS-1:0]   calc_age [tpst_pkg::WHEEL_SLOTS];

    logic [tpst_pkg::BYTE_W-1:0]      quot;
    logic [tpst_pkg::BYTE_W-1:0]      press;
    logic                             any_hit;
    logic [tpst_pkg::WIDX_W-1:0]      hit_idx;
    logic                             n_warn;
    logic [tpst_pkg::WHEEL_SLOTS-1:0] n_no_sig;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tpst_pkg::WHEEL_SLOTS; i++) begin
                r_wheel_addr[i] <= '0;
            end
            r_limit   <= tpst_pkg::LIMIT_RESET;
            r_timeout <= tpst_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                tpst_pkg::CFG_WHEEL0, tpst_pkg::CFG_WHEEL1,
                tpst_pkg::CFG_WHEEL2, tpst_pkg::CFG_WHEEL3: begin
                    r_wheel_addr[i_cfg_index[tpst_pkg::WIDX_W-1:0]] <=
                        i_cfg_data[tpst_pkg::ADDR_W-1:0];
                end
                tpst_pkg::CFG_LIMIT: begin
                    r_limit <= i_cfg_data[tpst_pkg::BYTE_W-1:0];
                end
                tpst_pkg::CFG_TIMEOUT: begin
                    r_timeout <= i_cfg_data[tpst_pkg::TIME_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_addr <= i_sensor_address;
            r_batt <= i_battery_byte;
            r_temp <= i_temperature_byte;
            r_raw  <= i_raw_pressure;
            r_now  <= i_now_time;
        end
    end

    // calc stage: address compare, offset and reciprocal multiply, age compare
    always_comb begin
        calc_neg  = (r_raw < tpst_pkg::PRESS_OFFSET);
        calc_diff = calc_neg ? (tpst_pkg::PRESS_OFFSET - r_raw)
                             : (r_raw - tpst_pkg::PRESS_OFFSET);
        calc_hit  = '0;
        calc_over = '0;
        for (int i = 0; i < tpst_pkg::WHEEL_SLOTS; i++) begin
            calc_age[i] = r_now - r_w_seen[i];
            if (i < tpst_pkg::WHEEL_COUNT) begin
                calc_hit[i]  = (r_wheel_addr[i] == r_addr);
                calc_over[i] = (calc_age[i] > r_timeout);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_hit_vec  <= calc_hit;
            r_over_vec <= calc_over;
            r_prod     <= calc_diff * tpst_pkg::RECIP10;
            r_neg      <= calc_neg;
        end
    end

    // commit stage
    always_comb begin
        quot    = r_prod[tpst_pkg::RECIP_SHIFT +: tpst_pkg::BYTE_W];
        press   = r_neg ? (~quot + 8'd1) : quot;
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = tpst_pkg::WHEEL_SLOTS - 1; i >= 0; i--) begin
            if (r_hit_vec[i]) begin
                any_hit = 1'b1;
                hit_idx = tpst_pkg::WIDX_W'(i);
            end
        end
        n_warn   = r_warn;
        n_no_sig = r_no_sig;
        if (r_op == tpst_pkg::OP_PACKET) begin
            if (any_hit && (press < r_limit)) begin
                n_warn = 1'b1;
            end
        end else begin
            n_no_sig = r_no_sig | r_over_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tpst_pkg::WHEEL_SLOTS; i++) begin
                r_w_press[i] <= '0;
                r_w_temp[i]  <= '0;
                r_w_batt[i]  <= '0;
                r_w_seen[i]  <= '0;
            end
            r_no_sig <= '0;
            r_warn   <= 1'b0;
        end else if (i_cmd.commit) begin
            r_no_sig <= n_no_sig;
            r_warn   <= n_warn;
            if (r_op == tpst_pkg::OP_PACKET) begin
                if (any_hit) begin
                    r_w_press[hit_idx] <= press;
                    r_w_temp[hit_idx]  <= r_temp;
                    r_w_batt[hit_idx]  <= r_batt;
                    r_w_seen[hit_idx]  <= r_now;
                end
            end else begin
                for (int i = 0; i < tpst_pkg::WHEEL_SLOTS; i++) begin
                    if (r_over_vec[i]) begin
                        r_w_seen[i] <= r_now;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_matched <= (r_op == tpst_pkg::OP_PACKET) && any_hit;
            r_out_idx     <= (r_op == tpst_pkg::OP_PACKET) ? hit_idx : '0;
            r_out_press   <= ((r_op == tpst_pkg::OP_PACKET) && any_hit) ? press : '0;
            r_out_warn    <= n_warn;
            r_out_mask    <= n_no_sig;
        end
    end

    assign o_matched          = r_out_matched;
    assign o_wheel_index      = r_out_idx;
    assign o_decoded_pressure = r_out_press;
    assign o_warning          = r_out_warn;
    assign o_no_signal_mask   = r_out_mask;

endmodule

[rtl/tpst_ctrl.sv]
// Controller FSM: input handshake, calc/commit sequencing, output valid.
// Depends on tpst_pkg and tire_pressure_sensor_tracker_top_assert.svh.
`timescale 1ns / 1ps

`include "tire_pressure_sensor_tracker_top_assert.svh"

module tpst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output tpst_pkg::t_dp_cmd o_cmd
);

    tpst_pkg::t_state r_state;
    tpst_pkg::t_state n_state;
    logic             r_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpst_pkg::S_IDLE: begin
                if (i_valid) n_state = tpst_pkg::S_CALC;
            end
            tpst_pkg::S_CALC: begin
                n_state = tpst_pkg::S_COMMIT;
            end
            tpst_pkg::S_COMMIT: begin
                if (out_free) n_state = tpst_pkg::S_IDLE;
            end
            default: begin
                n_state = tpst_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            tpst_pkg::S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            tpst_pkg::S_CALC: begin
                o_cmd.calc = 1'b1;
            end
            tpst_pkg::S_COMMIT: begin
                o_cmd.commit = out_free;
            end
            default: begin
            end
        endcase
    end

    // output register valid; payload lives in the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

    `TPST_ASSERT_NEXT(a_accept_to_calc, i_valid && !o_stall, r_state == tpst_pkg::S_CALC, "transfer in did not start calc")
    `TPST_ASSERT_NOW(a_commit_no_overwrite, o_cmd.commit, !r_out_valid || !i_stall, "commit overwrote a pending result")
    `TPST_ASSERT_NOW(a_valid_from_commit, $rose(r_out_valid), $past(r_state) == tpst_pkg::S_COMMIT, "result valid without commit")
    `TPST_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(o_cmd), "more than one datapath command")

endmodule

[rtl/tire_pressure_sensor_tracker_top.sv]
// Top level of the tire pressure sensor tracker.
// Depends on tpst_pkg, tpst_ctrl and tpst_datapath.
//
// Usage:
//   Input channel (i_valid / o_stall): one item per transfer. op 0 is a
//   sensor packet matched against the four wheel addresses; op 1 checks
//   every wheel for timeout, marks it no-signal and restamps it.
//   Output channel (o_valid / i_stall): exactly one result per item.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data): indexes 0-3 wheel
//   addresses, 4 low-pressure limit, 5 signal timeout; others ignored.
//   Write config only while the block is idle.
// Timing:
//   An item runs through capture, calc (compare, reciprocal multiply, age
//   check) and commit, set by the controller's three-state sequence. The
//   result is held in the output register from commit; a new item is
//   taken only in idle, once the last one has committed.
// Reset (synchronous, active low) clears all wheel state, the warning and
//   no-signal marks, sets the limit to 32 and the timeout to 10000000.
// A stalled result holds; the next item may be accepted meanwhile and waits
//   in commit until the output register is free.
`timescale 1ns / 1ps

module tire_pressure_sensor_tracker_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_op,
    input  logic [tpst_pkg::ADDR_W-1:0]      i_sensor_address,
    input  logic [tpst_pkg::BYTE_W-1:0]      i_battery_byte,
    input  logic [tpst_pkg::BYTE_W-1:0]      i_temperature_byte,
    input  logic [tpst_pkg::RAW_W-1:0]       i_raw_pressure,
    input  logic [tpst_pkg::TIME_BITS-1:0]   i_now_time,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_matched,
    output logic [tpst_pkg::WIDX_W-1:0]      o_wheel_index,
    output logic [tpst_pkg::BYTE_W-1:0]      o_decoded_pressure,
    output logic                             o_warning,
    output logic [tpst_pkg::WHEEL_SLOTS-1:0] o_no_signal_mask,
    input  logic                             i_cfg_we,
    input  logic [tpst_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tpst_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    tpst_pkg::t_dp_cmd dp_cmd;

    tpst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (dp_cmd)
    );

    tpst_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .i_op               (i_op),
        .i_sensor_address   (i_sensor_address),
        .i_battery_byte     (i_battery_byte),
        .i_temperature_byte (i_temperature_byte),
        .i_raw_pressure     (i_raw_pressure),
        .i_now_time         (i_now_time),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_matched          (o_matched),
        .o_wheel_index      (o_wheel_index),
        .o_decoded_pressure (o_decoded_pressure),
        .o_warning          (o_warning),
        .o_no_signal_mask   (o_no_signal_mask)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for tire_pressure_sensor_tracker_top: directed and random
// sensor packets and timeout checks, each result compared with an in-bench wheel tracker.
// Depends on tpst_pkg and the tracker RTL.

module tb_top;

    localparam int PRESS_STEP     = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_SHOWN      = 10;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 260;
    localparam logic [tpst_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [tpst_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam logic [tpst_pkg::ADDR_W-1:0]    ADDR_ONES   = '1;
    localparam logic [tpst_pkg::TIME_BITS-1:0] TIME_ONES   = '1;

    typedef struct packed {
        tpst_pkg::t_op                  op;
        logic [tpst_pkg::ADDR_W-1:0]    addr;
        logic [tpst_pkg::BYTE_W-1:0]    battery;
        logic [tpst_pkg::BYTE_W-1:0]    temperature;
        logic [tpst_pkg::RAW_W-1:0]     raw;
        logic [tpst_pkg::TIME_BITS-1:0] now;
    } t_sensor_item;

    typedef struct packed {
        logic                             matched;
        logic [tpst_pkg::WIDX_W-1:0]      widx;
        logic [tpst_pkg::BYTE_W-1:0]      pressure;
        logic                             warning;
        logic [tpst_pkg::WHEEL_SLOTS-1:0] ns_mask;
    } t_wheel_report;

    logic                             i_clk              = 1'b0;
    logic                             i_rst_n            = 1'b0;
    logic                             i_valid            = 1'b0;
    logic                             o_stall;
    logic                             i_op               = 1'b0;
    logic [tpst_pkg::ADDR_W-1:0]      i_sensor_address   = '0;
    logic [tpst_pkg::BYTE_W-1:0]      i_battery_byte     = '0;
    logic [tpst_pkg::BYTE_W-1:0]      i_temperature_byte = '0;
    logic [tpst_pkg::RAW_W-1:0]       i_raw_pressure     = '0;
    logic [tpst_pkg::TIME_BITS-1:0]   i_now_time         = '0;
    logic                             o_valid;
    logic                             i_stall            = 1'b0;
    logic                             o_matched;
    logic [tpst_pkg::WIDX_W-1:0]      o_wheel_index;
    logic [tpst_pkg::BYTE_W-1:0]      o_decoded_pressure;
    logic                             o_warning;
    logic [tpst_pkg::WHEEL_SLOTS-1:0] o_no_signal_mask;
    logic                             i_cfg_we           = 1'b0;
    logic [tpst_pkg::CFG_IDX_W-1:0]   i_cfg_index        = '0;
    logic [tpst_pkg::CFG_DATA_W-1:0]  i_cfg_data         = '0;

    tire_pressure_sensor_tracker_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // tracker copy: settings and per-wheel state
    logic [tpst_pkg::ADDR_W-1:0]      cfg_wheel_addr [tpst_pkg::WHEEL_SLOTS];
    logic [tpst_pkg::BYTE_W-1:0]      cfg_low_limit;
    logic [tpst_pkg::TIME_BITS-1:0]   cfg_timeout;
    logic [tpst_pkg::BYTE_W-1:0]      trk_pressure [tpst_pkg::WHEEL_SLOTS];
    logic [tpst_pkg::BYTE_W-1:0]      trk_temperature [tpst_pkg::WHEEL_SLOTS];
    logic [tpst_pkg::BYTE_W-1:0]      trk_battery [tpst_pkg::WHEEL_SLOTS];
    logic [tpst_pkg::TIME_BITS-1:0]   trk_last_seen [tpst_pkg::WHEEL_SLOTS];
    logic [tpst_pkg::WHEEL_SLOTS-1:0] trk_marks;
    logic                             trk_warning;

    t_sensor_item  send_queue [$];
    t_wheel_report report_queue [$];
    t_sensor_item  cur_item;
    t_wheel_report obs_report;
    t_wheel_report exp_report;
    logic [tpst_pkg::TIME_BITS-1:0] now_base;
    int send_gap     = 0;
    int send_burst   = 0;
    int recv_gap     = 0;
    int recv_burst   = 0;
    int idle_cycles  = 0;
    int fail_count   = 0;

    function automatic logic [tpst_pkg::ADDR_W-1:0] rand56();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[tpst_pkg::ADDR_W-1:0];
    endfunction

    function automatic logic [tpst_pkg::TIME_BITS-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[tpst_pkg::TIME_BITS-1:0];
    endfunction

    // mostly short gaps, a few long ones, and occasional bursts with none
    function automatic int next_idle(inout int burst);
        int roll;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_wheel_report update_tracker(input t_sensor_item p);
        t_wheel_report r;
        int q;
        logic [tpst_pkg::BYTE_W-1:0] pr;
        logic [tpst_pkg::TIME_BITS-1:0] age;
        r = '0;
        if (p.op == tpst_pkg::OP_PACKET) begin
            for (int w = 0; w < tpst_pkg::WHEEL_COUNT; w++) begin
                if (!r.matched && cfg_wheel_addr[w] == p.addr) begin
                    // signed offset, truncated toward zero, low byte kept
                    q  = (int'(p.raw) - int'(tpst_pkg::PRESS_OFFSET)) / PRESS_STEP;
                    pr = q[tpst_pkg::BYTE_W-1:0];
                    trk_pressure[w]    = pr;
                    trk_temperature[w] = p.temperature;
                    trk_battery[w]     = p.battery;
                    trk_last_seen[w]   = p.now;
                    if (pr < cfg_low_limit) trk_warning = 1'b1;
                    r.matched  = 1'b1;
                    r.widx     = tpst_pkg::WIDX_W'(w);
                    r.pressure = pr;
                end
            end
        end else begin
            for (int w = 0; w < tpst_pkg::WHEEL_COUNT; w++) begin
                age = p.now - trk_last_seen[w];
                if (age > cfg_timeout) begin
                    trk_marks[w]     = 1'b1;
                    trk_last_seen[w] = p.now;
                end
            end
        end
        r.warning = trk_warning;
        r.ns_mask = trk_marks;
        return r;
    endfunction

    task automatic report_fail(input string what, input t_wheel_report want,
                               input t_wheel_report got);
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
            $write("%s: expected m=%0d w=%0d p=%0d warn=%0d ns=%b, ",
                   what, want.matched, want.widx, want.pressure, want.warning,
                   want.ns_mask);
            $display("got m=%0d w=%0d p=%0d warn=%0d ns=%b",
                     got.matched, got.widx, got.pressure, got.warning, got.ns_mask);
        end
    endtask

    task automatic write_reg(input logic [tpst_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tpst_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx) inside
            tpst_pkg::CFG_WHEEL0, tpst_pkg::CFG_WHEEL1,
            tpst_pkg::CFG_WHEEL2, tpst_pkg::CFG_WHEEL3:
                cfg_wheel_addr[idx[tpst_pkg::WIDX_W-1:0]] = data;
            tpst_pkg::CFG_LIMIT:   cfg_low_limit = data[tpst_pkg::BYTE_W-1:0];
            tpst_pkg::CFG_TIMEOUT: cfg_timeout   = data[tpst_pkg::TIME_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic add_packet(input logic [tpst_pkg::ADDR_W-1:0] addr,
                              input logic [tpst_pkg::RAW_W-1:0] raw,
                              input logic [tpst_pkg::TIME_BITS-1:0] now);
        t_sensor_item it;
        it.op          = tpst_pkg::OP_PACKET;
        it.addr        = addr;
        it.battery     = tpst_pkg::BYTE_W'($urandom);
        it.temperature = tpst_pkg::BYTE_W'($urandom);
        it.raw         = raw;
        it.now         = now;
        send_queue.push_back(it);
    endtask

    task automatic add_check(input logic [tpst_pkg::TIME_BITS-1:0] now);
        t_sensor_item it;
        it     = '0;
        it.op  = tpst_pkg::OP_CHECK;
        it.now = now;
        send_queue.push_back(it);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (send_queue.size() != 0 || i_valid || report_queue.size() != 0);
    endtask

    task automatic program_phase(input int mode, output int step_max);
        logic [tpst_pkg::ADDR_W-1:0] a [tpst_pkg::WHEEL_SLOTS];
        logic [tpst_pkg::CFG_DATA_W-1:0] junk;
        logic [tpst_pkg::BYTE_W-1:0] limit;
        logic [tpst_pkg::TIME_BITS-1:0] tmo;
        int roll;
        for (int w = 0; w < tpst_pkg::WHEEL_SLOTS; w++) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) a[w] = '0;
            else if (roll == 1) a[w] = ADDR_ONES;
            else if (w > 0 && roll < 4) a[w] = a[tpst_pkg::WIDX_W'($urandom_range(0, w - 1))];
            else a[w] = rand56();
            write_reg(tpst_pkg::CFG_IDX_W'(tpst_pkg::CFG_WHEEL0 + w), a[w]);
        end
        limit = tpst_pkg::BYTE_W'($urandom);
        case (mode)
            0: begin limit = '1; tmo = TIME_ONES; step_max = 1000; end
            1: begin limit = '0; tmo = rand48(); step_max = 1000; end
            2: begin tmo = tpst_pkg::TIMEOUT_RESET; step_max = 2000000; end
            3: begin
                tmo = tpst_pkg::TIME_BITS'($urandom_range(50, 500));
                step_max = 300;
            end
            default: begin tmo = '0; step_max = 3; end
        endcase
        junk = rand56();
        write_reg(tpst_pkg::CFG_LIMIT, {junk[tpst_pkg::CFG_DATA_W-1:tpst_pkg::BYTE_W], limit});
        write_reg(tpst_pkg::CFG_TIMEOUT, {junk[tpst_pkg::CFG_DATA_W-1:tpst_pkg::TIME_BITS], tmo});
    endtask

    task automatic gen_random(input int count, input int step_max);
        t_sensor_item it;
        int roll;
        for (int n = 0; n < count; n++) begin
            it.op = ($urandom_range(0, 99) < 15) ? tpst_pkg::OP_CHECK : tpst_pkg::OP_PACKET;
            roll = $urandom_range(0, 99);
            if (roll < 75)
                it.addr = cfg_wheel_addr[
                    tpst_pkg::WIDX_W'($urandom_range(0, tpst_pkg::WHEEL_COUNT - 1))];
            else if (roll < 85)
                it.addr = cfg_wheel_addr[
                    tpst_pkg::WIDX_W'($urandom_range(0, tpst_pkg::WHEEL_COUNT - 1))]
                    ^ (56'd1 << $urandom_range(0, tpst_pkg::ADDR_W - 1));
            else
                it.addr = rand56();
            it.battery     = tpst_pkg::BYTE_W'($urandom);
            it.temperature = tpst_pkg::BYTE_W'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 70) it.raw = tpst_pkg::RAW_W'($urandom);
            else if (roll < 90) it.raw = tpst_pkg::RAW_W'($urandom_range(100, 500));
            else it.raw = roll[0] ? '1 : '0;
            if ($urandom_range(0, 99) < 3) now_base = rand48();
            else now_base = now_base + tpst_pkg::TIME_BITS'($urandom_range(0, step_max));
            it.now = now_base;
            send_queue.push_back(it);
        end
    endtask

    // driver: one item on the port until its transfer, then an optional gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) report_queue.push_back(update_tracker(cur_item));
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (send_queue.size() != 0) begin
                    cur_item = send_queue.pop_front();
                    i_op               <= cur_item.op;
                    i_sensor_address   <= cur_item.addr;
                    i_battery_byte     <= cur_item.battery;
                    i_temperature_byte <= cur_item.temperature;
                    i_raw_pressure     <= cur_item.raw;
                    i_now_time         <= cur_item.now;
                    i_valid            <= 1'b1;
                    send_gap = next_idle(send_burst);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                obs_report = {o_matched, o_wheel_index, o_decoded_pressure, o_warning,
                              o_no_signal_mask};
                if (report_queue.size() == 0) begin
                    report_fail("unexpected result", '0, obs_report);
                end else begin
                    exp_report = report_queue.pop_front();
                    if (obs_report !== exp_report) report_fail("mismatch", exp_report, obs_report);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else begin
                recv_gap = next_idle(recv_burst);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tire_pressure_sensor_tracker_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [tpst_pkg::ADDR_W-1:0] addr2;
        logic [tpst_pkg::ADDR_W-1:0] addr3;
        int step_max;
        for (int w = 0; w < tpst_pkg::WHEEL_SLOTS; w++) begin
            cfg_wheel_addr[w]  = '0;
            trk_pressure[w]    = '0;
            trk_temperature[w] = '0;
            trk_battery[w]     = '0;
            trk_last_seen[w]   = '0;
        end
        cfg_low_limit = tpst_pkg::LIMIT_RESET;
        cfg_timeout   = tpst_pkg::TIMEOUT_RESET;
        trk_marks     = '0;
        trk_warning   = 1'b0;
        now_base      = 48'd100;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: every wheel address is zero, lowest wheel wins
        add_packet('0, 16'hFFFF, 48'd5);
        add_check(48'd10000000);
        add_packet(rand56() | 56'd1, 16'd200, 48'd20);
        wait_drained();

        addr2 = rand56();
        addr3 = rand56();
        write_reg(tpst_pkg::CFG_WHEEL0, '0);
        write_reg(tpst_pkg::CFG_WHEEL1, ADDR_ONES);
        write_reg(tpst_pkg::CFG_WHEEL2, addr2);
        write_reg(tpst_pkg::CFG_WHEEL3, addr3);
        write_reg(tpst_pkg::CFG_LIMIT, 56'd32);
        write_reg(tpst_pkg::CFG_TIMEOUT, 56'd100);
        write_reg(CFG_SPARE_A, rand56());
        write_reg(CFG_SPARE_B, rand56());

        add_packet('0, 16'd147, 48'd1000);
        add_packet(ADDR_ONES, 16'd156, 48'd1000);
        add_packet(addr2, 16'd157, 48'd1000);
        add_packet(addr3, 16'd0, 48'd1000);
        add_packet(addr2, 16'd146, 48'd1050);
        add_packet(addr3, 16'd137, 48'd1050);
        add_packet(ADDR_ONES, 16'hFFFF, 48'd1050);
        add_check(48'd1100);
        add_check(48'd1101);
        add_check(48'd1101);
        // marked wheel keeps its mark on new data; then ages across the time wrap
        add_packet('0, 16'd300, TIME_ONES - 48'd10);
        add_packet(ADDR_ONES, 16'd400, TIME_ONES - 48'd5);
        add_packet(addr2, 16'd500, TIME_ONES - 48'd5);
        add_packet(addr3, 16'd600, TIME_ONES);
        add_check(48'd20);
        add_packet(ADDR_ONES ^ 56'd1, 16'd500, 48'd30);
        wait_drained();

        for (int mode = 0; mode < RANDOM_PHASES; mode++) begin
            program_phase(mode, step_max);
            gen_random(PHASE_ITEMS, step_max);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (report_queue.size() != 0) begin
            fail_count += report_queue.size();
            $display("%0d results never arrived", report_queue.size());
        end
        if (fail_count == 0) $display("tire_pressure_sensor_tracker_top verification clean");
        else $display("tire_pressure_sensor_tracker_top verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/tpst_pkg.sv
rtl/tpst_datapath.sv
rtl/tpst_ctrl.sv
rtl/tire_pressure_sensor_tracker_top.sv
tb/tb_top.sv
